@@ hdl/ecsm_pkg.sv @@
// shared types and constants for the cached-doubles scalar multiplier
package ecsm_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MODULUS = 2'd0;
	localparam logic [1:0] REG_GEN_X   = 2'd1;
	localparam logic [1:0] REG_GEN_Y   = 2'd2;

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD_GEN = 4'd1;  // start reduction of gen_x
	localparam logic [3:0] OP_RED_Y    = 4'd2;  // start reduction of gen_y
	localparam logic [3:0] OP_ADD      = 4'd3;  // acc = acc + tbl entry
	localparam logic [3:0] OP_DBL      = 4'd4;  // cur = cur + cur
	localparam logic [3:0] OP_CLR_ACC  = 4'd5;
	localparam logic [3:0] OP_WR_TBL   = 4'd6;
	localparam logic [3:0] OP_RD_TBL   = 4'd7;

	// controller to datapath
	typedef struct packed {
		logic [3:0] op;
		logic [5:0] idx;
	} ecsm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;
		logic small_mod;
	} ecsm_sts_t;

endpackage

@@ hdl/ec_scalar_mult_cached_doubles.sv @@
// top level: elliptic curve scalar multiplier with cached generator doublings
//
//  channel | signals                          | direction
//  cfg     | cfg_valid cfg_ready cfg_index/data| in
//  in      | in_valid in_stall scalar         | in
//  out     | out_valid out_stall res_x res_y at_infinity | out
//
// one key takes one point addition per set bit below KEY_BITS; each addition
// runs euclid steps of one serial divide and one serial multiply
// plus three multiplies, or five when the two points are equal.
// after reset and after each register write the doubles table is rebuilt
// (KEY_BITS-1 doublings) before the next key is taken.
// the result register holds while out_stall is high; a new key is taken
// once the previous result has been loaded into the result register.
module ec_scalar_mult_cached_doubles #(
	parameter int KEY_BITS   = 32,
	parameter int FIELD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] scalar,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] res_x,
	output logic [31:0] res_y,
	output logic        at_infinity
);
	import ecsm_pkg::*;

	logic [31:0] modulus_q, gen_x_q, gen_y_q;
	logic        wr, take, load, valid_q;
	ecsm_cmd_t   cmd;
	ecsm_sts_t   sts;
	logic [FIELD_BITS-1:0] ax, ay;
	logic        ainf;
	logic [KEY_BITS-1:0] key;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 32'd3;
			gen_x_q   <= '0;
			gen_y_q   <= '0;
		end else if (wr) begin
			unique case (cfg_index)
				REG_MODULUS: modulus_q <= cfg_data;
				REG_GEN_X:   gen_x_q   <= cfg_data;
				REG_GEN_Y:   gen_y_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key = (KEY_BITS >= 32) ? KEY_BITS'(scalar) : scalar[KEY_BITS-1:0];
	assign in_stall = !take;

	ecsm_ctrl #(.KEY_BITS(KEY_BITS)) u_ctrl (
		.clk, .arst_n,
		.rebuild  (wr && (cfg_index == REG_MODULUS || cfg_index == REG_GEN_X ||
		                  cfg_index == REG_GEN_Y)),
		.in_valid,
		.key,
		.in_take  (take),
		.out_load (load),
		.out_free (!valid_q),
		.cmd, .sts
	);

	ecsm_dp #(.KEY_BITS(KEY_BITS), .FIELD_BITS(FIELD_BITS)) u_dp (
		.clk, .arst_n,
		.modulus (modulus_q), .gen_x (gen_x_q), .gen_y (gen_y_q),
		.cmd, .sts,
		.acc_x (ax), .acc_y (ay), .acc_inf (ainf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (load) valid_q <= 1'b1;
		else if (!out_stall) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			at_infinity <= ainf || sts.small_mod;
			res_x <= (ainf || sts.small_mod) ? 32'd0 : 32'(ax);
			res_y <= (ainf || sts.small_mod) ? 32'd0 : 32'(ay);
		end
	end

	assign out_valid = valid_q;
endmodule

@@ hdl/ecsm_ctrl.sv @@
// controller: table build sequencing and per-key bit walk
module ecsm_ctrl #(
	parameter int KEY_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rebuild,
	input  logic               in_valid,
	input  logic [KEY_BITS-1:0] key,
	output logic               in_take,
	output logic               out_load,
	input  logic               out_free,
	output ecsm_pkg::ecsm_cmd_t cmd,
	input  ecsm_pkg::ecsm_sts_t sts
);
	import ecsm_pkg::*;

	localparam int IW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	localparam logic [3:0] S_BUILD0 = 4'd0;
	localparam logic [3:0] S_BW1    = 4'd1;
	localparam logic [3:0] S_BW2    = 4'd2;
	localparam logic [3:0] S_TWR    = 4'd3;
	localparam logic [3:0] S_TDBL   = 4'd4;
	localparam logic [3:0] S_TDW    = 4'd5;
	localparam logic [3:0] S_IDLE   = 4'd6;
	localparam logic [3:0] S_BIT    = 4'd7;
	localparam logic [3:0] S_RDW    = 4'd8;
	localparam logic [3:0] S_ADD    = 4'd9;
	localparam logic [3:0] S_ADW    = 4'd10;
	localparam logic [3:0] S_OUT    = 4'd11;
	localparam logic [3:0] S_BW0    = 4'd12;

	logic [3:0]          state_q;
	logic [IW-1:0]       idx_q;
	logic [KEY_BITS-1:0] key_q;
	logic                pend_q;
	logic                last;

	assign last = (idx_q == IW'(KEY_BITS - 1));

	// command decode
	always_comb begin
		cmd.op  = OP_NONE;
		cmd.idx = 6'(idx_q);
		in_take = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_BUILD0: cmd.op = OP_LOAD_GEN;
			S_BW1:    cmd.op = sts.busy ? OP_NONE : OP_RED_Y;
			S_TWR:    cmd.op = OP_WR_TBL;
			S_TDBL:   cmd.op = last ? OP_NONE : OP_DBL;
			S_IDLE: begin
				in_take = in_valid && !pend_q;
				cmd.op  = in_take ? OP_CLR_ACC : OP_NONE;
			end
			S_BIT:    cmd.op = key_q[idx_q] ? OP_RD_TBL : OP_NONE;
			S_ADD:    cmd.op = OP_ADD;
			S_OUT:    out_load = out_free;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_BUILD0;
			idx_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			// a write during the generator load must trigger another build
			pend_q <= rebuild || (pend_q && state_q != S_BUILD0);
			unique case (state_q)
				S_BUILD0: begin
					idx_q   <= '0;
					state_q <= S_BW0;
				end
				S_BW0: state_q <= S_BW1;
				S_BW1: if (!sts.busy) state_q <= S_BW2;
				S_BW2: if (!sts.busy) state_q <= S_TWR;
				S_TWR: state_q <= S_TDBL;
				S_TDBL: begin
					if (last) state_q <= S_IDLE;
					else state_q <= S_TDW;
				end
				S_TDW: if (!sts.busy) begin
					idx_q   <= idx_q + 1'b1;
					state_q <= S_TWR;
				end
				S_IDLE: begin
					if (pend_q) state_q <= S_BUILD0;
					else if (in_valid) begin
						idx_q   <= '0;
						state_q <= sts.small_mod ? S_OUT : S_BIT;
					end
				end
				S_BIT: state_q <= key_q[idx_q] ? S_RDW : (last ? S_OUT : S_BIT);
				S_RDW: state_q <= S_ADD;
				S_ADD: state_q <= S_ADW;
				S_ADW: if (!sts.busy) state_q <= last ? S_OUT : S_BIT;
				S_OUT: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_BUILD0;
			endcase
			if ((state_q == S_BIT && !key_q[idx_q] && !last) ||
			    (state_q == S_ADW && !sts.busy && !last))
				idx_q <= idx_q + 1'b1;
		end
	end

	// key holding register
	always_ff @(posedge clk) begin
		if (in_take) key_q <= key;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> !in_take)
		else $error("back to back key take");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !in_take)
		else $error("take while delivering");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |=> (state_q == S_ADW))
		else $error("add did not move to its wait state");
endmodule

@@ hdl/ecsm_dp.sv @@
// datapath: modular arithmetic, point add/double, doubles table
module ecsm_dp #(
	parameter int KEY_BITS   = 32,
	parameter int FIELD_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           modulus,
	input  logic [31:0]           gen_x,
	input  logic [31:0]           gen_y,
	input  ecsm_pkg::ecsm_cmd_t   cmd,
	output ecsm_pkg::ecsm_sts_t   sts,
	output logic [FIELD_BITS-1:0] acc_x,
	output logic [FIELD_BITS-1:0] acc_y,
	output logic                  acc_inf
);
	import ecsm_pkg::*;

	localparam int W  = FIELD_BITS;
	localparam int CW = $clog2(W + 1);
	localparam int IW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	// micro sequencer states
	localparam logic [4:0] U_IDLE  = 5'd0;
	localparam logic [4:0] U_REDX  = 5'd1;
	localparam logic [4:0] U_REDY  = 5'd2;
	localparam logic [4:0] U_CHK   = 5'd3;
	localparam logic [4:0] U_XX    = 5'd4;
	localparam logic [4:0] U_X3    = 5'd5;
	localparam logic [4:0] U_INV0  = 5'd6;
	localparam logic [4:0] U_DIV   = 5'd7;
	localparam logic [4:0] U_QT    = 5'd8;
	localparam logic [4:0] U_UPD   = 5'd9;
	localparam logic [4:0] U_SL    = 5'd10;
	localparam logic [4:0] U_SS    = 5'd11;
	localparam logic [4:0] U_RX    = 5'd12;
	localparam logic [4:0] U_RY    = 5'd13;
	localparam logic [4:0] U_FIN   = 5'd14;
	localparam logic [4:0] U_INF   = 5'd15;

	logic [W-1:0] m;
	logic         m_small;
	logic [W-1:0] gx, gy;

	assign gx = (W >= 32) ? W'(gen_x) : gen_x[W-1:0];
	assign gy = (W >= 32) ? W'(gen_y) : gen_y[W-1:0];
	assign m  = (W >= 32) ? W'(modulus) : modulus[W-1:0];
	assign m_small = (m < W'(3));

	// point registers
	logic [W-1:0] cx_q, cy_q, ax_q, ay_q, px_q, py_q, qx_q, qy_q;
	logic         cinf_q, ainf_q;
	logic         to_acc_q;
	logic [W-1:0] num_q, den_q, s_q, rx_q, t_q;
	logic [4:0]   u_q;

	// doubles table memory
	logic [2*W:0] tbl [KEY_BITS];
	logic [2*W:0] rd_q;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WR_TBL) tbl[cmd.idx[IW-1:0]] <= {cinf_q, cx_q, cy_q};
		if (cmd.op == OP_RD_TBL) rd_q <= tbl[cmd.idx[IW-1:0]];
	end

	// shift-add modular multiplier, one bit per cycle
	logic         mul_go, mul_busy_q;
	logic [W-1:0] mul_a, mul_b, mul_a_q, mul_b_q, mul_r_q;
	logic [CW-1:0] mul_n_q;
	logic [W-1:0] r1;

	function automatic logic [W-1:0] madd(input logic [W-1:0] a, input logic [W-1:0] b,
		input logic [W-1:0] mm);
		logic [W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= {1'b0, mm}) ? W'(s - {1'b0, mm}) : W'(s);
	endfunction

	function automatic logic [W-1:0] msub(input logic [W-1:0] a, input logic [W-1:0] b,
		input logic [W-1:0] mm);
		return (a >= b) ? W'(a - b) : W'(a + (mm - b));
	endfunction

	always_comb begin
		r1 = madd(mul_r_q, mul_r_q, m);
		if (mul_b_q[W-1]) r1 = madd(r1, mul_a_q, m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mul_n_q    <= '0;
		end else if (mul_go) begin
			mul_busy_q <= 1'b1;
			mul_n_q    <= CW'(W);
		end else if (mul_busy_q) begin
			mul_n_q <= mul_n_q - 1'b1;
			if (mul_n_q == CW'(1)) mul_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mul_go) begin
			mul_a_q <= mul_a;
			mul_b_q <= mul_b;
			mul_r_q <= '0;
		end else if (mul_busy_q) begin
			mul_r_q <= r1;
			mul_b_q <= mul_b_q << 1;
		end
	end

	// restoring divider, one quotient bit per cycle (also reduces mod m)
	logic          div_go, div_busy_q;
	logic [W-1:0]  div_n, div_d, div_q_q, div_r_q, div_d_q, div_nn_q;
	logic [CW-1:0] div_c_q;
	logic [W:0]    div_t;

	assign div_t = {div_r_q, div_nn_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_c_q    <= '0;
		end else if (div_go) begin
			div_busy_q <= 1'b1;
			div_c_q    <= CW'(W);
		end else if (div_busy_q) begin
			div_c_q <= div_c_q - 1'b1;
			if (div_c_q == CW'(1)) div_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_go) begin
			div_nn_q <= div_n;
			div_d_q  <= div_d;
			div_r_q  <= '0;
			div_q_q  <= '0;
		end else if (div_busy_q) begin
			div_nn_q <= div_nn_q << 1;
			if (div_t >= {1'b0, div_d_q}) begin
				div_r_q <= W'(div_t - {1'b0, div_d_q});
				div_q_q <= {div_q_q[W-2:0], 1'b1};
			end else begin
				div_r_q <= W'(div_t);
				div_q_q <= {div_q_q[W-2:0], 1'b0};
			end
		end
	end

	// extended euclid registers
	logic [W-1:0] e_r0_q, e_r1_q, e_t0_q, e_t1_q;
	logic         dbl_mode_q;

	// sequencer
	always_comb begin
		mul_go = 1'b0; mul_a = '0; mul_b = '0;
		div_go = 1'b0; div_n = '0; div_d = '0;
		unique case (u_q)
			U_IDLE: begin
				if (cmd.op == OP_LOAD_GEN) begin
					div_go = !m_small; div_n = gx; div_d = m;
				end else if (cmd.op == OP_RED_Y) begin
					div_go = !m_small; div_n = gy; div_d = m;
				end
			end
			U_X3: if (!mul_busy_q) begin
				mul_go = 1'b1; mul_a = mul_r_q; mul_b = W'(3);
			end
			U_INV0, U_UPD: ;
			U_DIV: ;
			U_QT: if (!div_busy_q) begin
				mul_go = 1'b1; mul_a = div_q_q; mul_b = e_t1_q;
			end
			U_SL: if (!mul_busy_q) begin
				mul_go = 1'b1; mul_a = num_q; mul_b = e_t0_q;
			end
			U_SS: if (!mul_busy_q) begin
				mul_go = 1'b1; mul_a = mul_r_q; mul_b = mul_r_q;
			end
			// s*s is ready here, so the new x is formed on the fly
			U_RX: if (!mul_busy_q) begin
				mul_go = 1'b1; mul_a = s_q;
				mul_b  = msub(px_q, msub(msub(mul_r_q, px_q, m), qx_q, m), m);
			end
			default: ;
		endcase
		if (u_q == U_CHK && px_q == qx_q && py_q == qy_q && py_q != '0) begin
			mul_go = 1'b1; mul_a = px_q; mul_b = px_q;
		end
		if (u_q == U_INV0 && den_q != '0 && (!dbl_mode_q || !mul_busy_q)) begin
			div_go = 1'b1; div_n = m; div_d = den_q;
		end
		if (u_q == U_UPD && !mul_busy_q && t_q != '0) begin
			div_go = 1'b1; div_n = e_r1_q; div_d = t_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_q    <= U_IDLE;
			cinf_q <= 1'b1;
			ainf_q <= 1'b1;
		end else begin
			unique case (u_q)
				U_IDLE: begin
					unique case (cmd.op)
						OP_LOAD_GEN: begin
							if (m_small) cinf_q <= 1'b1;
							else begin
								cinf_q <= 1'b0;
								u_q    <= U_REDX;
							end
						end
						OP_RED_Y: if (!m_small) u_q <= U_REDY;
						OP_CLR_ACC: ainf_q <= 1'b1;
						OP_DBL: begin
							if (!cinf_q) begin
								to_acc_q <= 1'b0;
								px_q <= cx_q; py_q <= cy_q;
								qx_q <= cx_q; qy_q <= cy_q;
								u_q  <= U_CHK;
							end
						end
						OP_ADD: begin
							to_acc_q <= 1'b1;
							if (rd_q[2*W]) ;
							else if (ainf_q) begin
								ax_q <= rd_q[2*W-1:W]; ay_q <= rd_q[W-1:0];
								ainf_q <= 1'b0;
							end else begin
								px_q <= ax_q; py_q <= ay_q;
								qx_q <= rd_q[2*W-1:W]; qy_q <= rd_q[W-1:0];
								u_q  <= U_CHK;
							end
						end
						default: ;
					endcase
				end
				U_REDX: if (!div_busy_q) begin
					cx_q <= div_r_q;
					u_q  <= U_IDLE;
				end
				U_REDY: if (!div_busy_q) begin
					cy_q <= div_r_q;
					u_q  <= U_IDLE;
				end
				U_CHK: begin
					if (px_q == qx_q) begin
						if (py_q != qy_q || py_q == '0) u_q <= U_INF;
						else begin
							dbl_mode_q <= 1'b1;
							den_q <= madd(py_q, py_q, m);
							u_q   <= U_XX;
						end
					end else begin
						dbl_mode_q <= 1'b0;
						num_q <= msub(qy_q, py_q, m);
						den_q <= msub(qx_q, px_q, m);
						u_q   <= U_INV0;
					end
				end
				U_XX: u_q <= U_X3;
				U_X3: if (!mul_busy_q) u_q <= U_INV0;
				U_INV0: begin
					if (dbl_mode_q && !mul_busy_q) num_q <= mul_r_q;
					if (!dbl_mode_q || !mul_busy_q) begin
						e_r0_q <= m; e_r1_q <= den_q;
						e_t0_q <= '0; e_t1_q <= W'(1);
						u_q <= (den_q == '0) ? U_INF : U_DIV;
					end
				end
				U_DIV: u_q <= U_QT;
				U_QT: if (!div_busy_q) begin
					t_q <= div_r_q;
					u_q <= U_UPD;
				end
				U_UPD: if (!mul_busy_q) begin
					e_r0_q <= e_r1_q; e_r1_q <= t_q;
					e_t0_q <= e_t1_q; e_t1_q <= msub(e_t0_q, mul_r_q, m);
					if (t_q == '0) begin
						u_q <= (e_r1_q == W'(1)) ? U_SL : U_INF;
						e_t0_q <= e_t1_q;
					end else u_q <= U_QT;
				end
				U_SL: if (!mul_busy_q) u_q <= U_SS;
				U_SS: if (!mul_busy_q) begin
					s_q <= mul_r_q;
					u_q <= U_RX;
				end
				U_RX: if (!mul_busy_q) begin
					rx_q <= msub(msub(mul_r_q, px_q, m), qx_q, m);
					u_q  <= U_RY;
				end
				U_RY: if (!mul_busy_q) u_q <= U_FIN;
				U_FIN: begin
					if (to_acc_q) begin
						ax_q <= rx_q; ay_q <= msub(mul_r_q, py_q, m);
						ainf_q <= 1'b0;
					end else begin
						cx_q <= rx_q; cy_q <= msub(mul_r_q, py_q, m);
						cinf_q <= 1'b0;
					end
					u_q <= U_IDLE;
				end
				U_INF: begin
					if (to_acc_q) ainf_q <= 1'b1;
					else cinf_q <= 1'b1;
					u_q <= U_IDLE;
				end
				default: u_q <= U_IDLE;
			endcase
		end
	end

	// status back to the controller
	assign sts.busy      = (u_q != U_IDLE) || mul_busy_q || div_busy_q;
	assign sts.small_mod = m_small;
	assign acc_x   = ax_q;
	assign acc_y   = ay_q;
	assign acc_inf = ainf_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		mul_go |-> !mul_busy_q)
		else $error("multiplier restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		div_go |-> !div_busy_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		(u_q == U_FIN) |=> (u_q == U_IDLE))
		else $error("finish did not return to idle");
endmodule

@@ tb/sv/tb.sv @@
// testbench for the cached-doubles elliptic curve scalar multiplier
`timescale 1ns / 1ps

module tb;
	import ecsm_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;  // index with no register behind it
	localparam int KEY_BITS   = 32;
	localparam int HOLD_CYCLES = 30000;
	localparam longint CYCLE_LIMIT = 80_000_000;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic        inf;
	} point_t;

	typedef struct {
		logic [31:0] key;
		logic        typed;  // expected point given in the row
		point_t      pt;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] scalar;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] res_x;
	logic [31:0] res_y;
	logic        at_infinity;

	// own copy of the configuration and the doublings
	logic [31:0] cur_mod;
	logic [31:0] cur_gx;
	logic [31:0] cur_gy;
	point_t      dbl_pts [KEY_BITS];

	point_t      products [$];
	int          errors;
	int          n_checked;
	int          n_inf;
	int          send_idle;
	int          recv_idle;
	logic        hold_go;
	int          hold_left;
	longint      cycles;

	ec_scalar_mult_cached_doubles uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .scalar(scalar),
		.out_valid(out_valid), .out_stall(out_stall),
		.res_x(res_x), .res_y(res_y), .at_infinity(at_infinity)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// field arithmetic, operands below m
	function automatic longint unsigned f_mul(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return (a * b) % m;
	endfunction

	function automatic longint unsigned f_sub(longint unsigned a, longint unsigned b,
			longint unsigned m);
		return (a >= b) ? a - b : a + (m - b);
	endfunction

	// extended euclid; ok is low when gcd is not one
	function automatic longint unsigned f_inv(longint unsigned a, longint unsigned m,
			output logic ok);
		longint unsigned r0, r1, t0, t1, q, nr, nt;
		r0 = m;
		r1 = a;
		t0 = 0;
		t1 = 1;
		while (r1 != 0) begin
			q  = r0 / r1;
			nr = r0 - q * r1;
			nt = f_sub(t0, f_mul(q % m, t1, m), m);
			r0 = r1;
			r1 = nr;
			t0 = t1;
			t1 = nt;
		end
		ok = (r0 == 1);
		return t0;
	endfunction

	// affine point sum, infinity on vertical line or missing inverse
	function automatic point_t curve_sum(point_t p, point_t q, longint unsigned m);
		point_t r;
		longint unsigned num, den, inv, s, rx;
		logic ok;
		r = '{32'd0, 32'd0, 1'b1};
		if (p.inf)
			return q;
		if (q.inf)
			return p;
		if (p.x == q.x) begin
			if (p.y != q.y || p.y == 0)
				return r;
			num = f_mul(3 % m, f_mul(p.x, p.x, m), m);
			den = (2 * longint'(p.y)) % m;
		end else begin
			num = f_sub(q.y, p.y, m);
			den = f_sub(q.x, p.x, m);
		end
		inv = f_inv(den, m, ok);
		if (!ok)
			return r;
		s  = f_mul(num, inv, m);
		rx = f_sub(f_sub(f_mul(s, s, m), p.x, m), q.x, m);
		r.x = 32'(rx);
		r.y = 32'(f_sub(f_mul(s, f_sub(p.x, rx, m), m), p.y, m));
		r.inf = 1'b0;
		return r;
	endfunction

	task automatic rebuild_doublings();
		point_t cur;
		longint unsigned m;
		m = cur_mod;
		cur.x = (m < 3) ? 32'd0 : 32'(cur_gx % m);
		cur.y = (m < 3) ? 32'd0 : 32'(cur_gy % m);
		cur.inf = (m < 3);
		for (int i = 0; i < KEY_BITS; i++) begin
			dbl_pts[i] = cur;
			if (m >= 3)
				cur = curve_sum(cur, cur, m);
		end
	endtask

	function automatic point_t key_product(logic [31:0] key);
		point_t acc;
		acc = '{32'd0, 32'd0, 1'b1};
		if (cur_mod >= 3)
			for (int i = 0; i < KEY_BITS; i++)
				if (key[i])
					acc = curve_sum(acc, dbl_pts[i], cur_mod);
		if (acc.inf) begin
			acc.x = 0;
			acc.y = 0;
		end
		return acc;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d products pending", cycles, products.size());
			$display("tb: FAIL");
			$finish;
		end
	end

	// long receiver hold-off counter
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// result check and receiver stall
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (products.size() == 0) begin
				report("unexpected transfer x", res_x, 32'd0);
			end else begin
				want = products.pop_front();
				n_checked++;
				if (want.inf)
					n_inf++;
				if (at_infinity !== want.inf)
					report("at_infinity", 32'(at_infinity), 32'(want.inf));
				if (res_x !== want.x)
					report("res_x", res_x, want.x);
				if (res_y !== want.y)
					report("res_y", res_y, want.y);
			end
		end
		out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_idle);
	end

	task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
		wait (products.size() == 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MODULUS: cur_mod = val;
			REG_GEN_X:   cur_gx = val;
			REG_GEN_Y:   cur_gy = val;
			default: ;
		endcase
		rebuild_doublings();
	endtask

	task automatic set_curve(logic [31:0] m, logic [31:0] gx, logic [31:0] gy);
		cfg_write(REG_MODULUS, m);
		cfg_write(REG_GEN_X, gx);
		cfg_write(REG_GEN_Y, gy);
	endtask

	// offer one key, valid stays high across back-to-back transfers
	task automatic send_key(logic [31:0] key, logic typed, point_t pt);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		scalar   <= key;
		do
			@(posedge clk);
		while (in_stall);
		products.push_back(typed ? pt : key_product(key));
	endtask

	// mostly sparse keys, since each set bit costs a point addition
	function automatic logic [31:0] rand_key();
		logic [31:0] k;
		int sel;
		sel = $urandom_range(99);
		if (sel < 5)
			return 32'd0;
		if (sel < 12)
			return $urandom();
		k = 0;
		for (int i = $urandom_range(1, 4); i > 0; i--)
			k[$urandom_range(31)] = 1'b1;
		return k;
	endfunction

	task automatic send_random(int n);
		point_t none;
		none = '{32'd0, 32'd0, 1'b0};
		for (int i = 0; i < n; i++)
			send_key(rand_key(), 1'b0, none);
		in_valid <= 1'b0;
	endtask

	stim_row_t rows [] = '{
		// reset curve: modulus 3, generator (0,0), its double is infinity
		'{32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}},
		'{32'h0000_0001, 1'b1, '{32'd0, 32'd0, 1'b0}},
		'{32'h8000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}},
		'{32'hFFFF_FFFF, 1'b1, '{32'd0, 32'd0, 1'b0}},
		'{32'h0000_0002, 1'b1, '{32'd0, 32'd0, 1'b1}},
		'{32'h0000_0003, 1'b1, '{32'd0, 32'd0, 1'b0}}
	};

	stim_row_t rows_big [] = '{
		'{32'h0000_0001, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'h0000_0002, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'h0000_0003, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'h8000_0000, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'h5555_5555, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'hAAAA_AAAA, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'hFFFF_FFFF, 1'b0, '{32'd0, 32'd0, 1'b0}},
		'{32'h0000_0000, 1'b1, '{32'd0, 32'd0, 1'b1}}
	};

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data  = 32'd0;
		in_valid  = 1'b0;
		scalar    = 32'd0;
		out_stall = 1'b0;
		hold_go   = 1'b0;
		cycles    = 0;
		errors    = 0;
		n_checked = 0;
		n_inf     = 0;
		send_idle = 24;
		recv_idle = 48;
		cur_mod   = 32'd3;
		cur_gx    = 32'd0;
		cur_gy    = 32'd0;
		rebuild_doublings();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed keys on the reset curve
		foreach (rows[i])
			send_key(rows[i].key, rows[i].typed, rows[i].pt);
		in_valid <= 1'b0;

		// largest 32-bit prime, generator with all bits toggling
		set_curve(32'hFFFF_FFFB, 32'h8000_0001, 32'h7FFF_FFFE);
		foreach (rows_big[i])
			send_key(rows_big[i].key, rows_big[i].typed, rows_big[i].pt);
		in_valid <= 1'b0;
		send_random(16);

		// receiver holds off while keys keep coming
		wait (products.size() == 0);
		@(posedge clk);
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		send_random(16);

		// composite all-ones modulus, write to the unused index is ignored
		set_curve(32'hFFFF_FFFF, $urandom(), $urandom());
		cfg_write(REG_UNUSED, $urandom());
		send_random(16);

		send_idle = 48;
		recv_idle = 24;
		// small composite modulus, many missing inverses
		set_curve(32'd15, 32'd2, 32'd3);
		send_random(16);

		// small prime with generator not reduced
		set_curve(32'd97, 32'd1000, 32'hFFFF_FFFF);
		send_random(16);

		// modulus below three gives infinity everywhere
		cfg_write(REG_MODULUS, 32'd1);
		send_random(8);
		cfg_write(REG_MODULUS, 32'd0);
		send_random(4);
		cfg_write(REG_MODULUS, 32'd2);
		send_random(4);

		send_idle = 0;
		recv_idle = 0;
		set_curve(32'd2_147_483_647, $urandom(), $urandom());
		send_random(24);

		set_curve(32'd65_521, 32'd0, 32'd0);
		send_random(12);

		wait (products.size() == 0);
		repeat (100) @(posedge clk);
		if (products.size() != 0)
			report("products left over", 32'(products.size()), 32'd0);
		$display("covered %0d products (%0d at infinity) over prime, composite and tiny moduli",
			n_checked, n_inf);
		$display("with sender and receiver idling, one long receiver hold-off and config phases");
		if (errors == 0) begin
			$display("tb: PASS");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/ecsm_pkg.sv
hdl/ecsm_ctrl.sv
hdl/ecsm_dp.sv
hdl/ec_scalar_mult_cached_doubles.sv
tb/sv/tb.sv
